// ----- design/psr_pkg.sv -----
`default_nettype none
package psr_pkg;

    localparam int unsigned CORD_W = 34;
    localparam int unsigned PROD_W = 68;
    localparam int unsigned ACC_W  = 69;

    typedef logic signed [CORD_W-1:0] t_coord;

    localparam t_coord CORDIC_START = 34'sd652032874;
    localparam t_coord QUARTER_TURN = 34'sd1073741824;
    localparam t_coord HALF_TURN    = 34'sd2147483648;

    typedef enum logic [1:0] {
        REG_POLE_LONGITUDE = 2'd0,
        REG_POLE_LATITUDE  = 2'd1,
        REG_SPIN_RATE      = 2'd2,
        REG_UNUSED         = 2'd3
    } t_reg_index;

    function automatic logic [31:0] f_atan(input int unsigned i);
        logic [31:0] r;
        case (i)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/psr_cordic.sv -----
`default_nettype none
module psr_cordic #(
    parameter int unsigned ITER = 24
) (
    input  wire logic          i_clk,
    input  wire logic [31:0]   i_ang,
    output psr_pkg::t_coord    o_cos,
    output psr_pkg::t_coord    o_sin
);

    psr_pkg::t_coord r_x [0:ITER];
    psr_pkg::t_coord r_y [0:ITER];
    psr_pkg::t_coord r_z [0:ITER];
    logic            r_neg [0:ITER];

    psr_pkg::t_coord n_z0;
    logic            n_neg0;

    // fold into [-1/4, +1/4] turn
    always_comb begin
        n_z0  = psr_pkg::t_coord'($signed(i_ang));
        n_neg0 = 1'b0;
        if (n_z0 > psr_pkg::QUARTER_TURN) begin
            n_z0  = n_z0 - psr_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end else if (n_z0 < -psr_pkg::QUARTER_TURN) begin
            n_z0  = n_z0 + psr_pkg::HALF_TURN;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= psr_pkg::CORDIC_START;
        r_y[0]   <= '0;
        r_z[0]   <= n_z0;
        r_neg[0] <= n_neg0;
    end

    for (genvar k = 0; k < ITER; k++) begin : g_iter
        localparam psr_pkg::t_coord ATAN = $signed({2'b00, psr_pkg::f_atan(k)});
        always_ff @(posedge i_clk) begin
            r_neg[k+1] <= r_neg[k];
            if (!r_z[k][psr_pkg::CORD_W-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN;
            end
        end
    end

    assign o_cos = r_neg[ITER] ? -r_x[ITER] : r_x[ITER];
    assign o_sin = r_neg[ITER] ? -r_y[ITER] : r_y[ITER];

endmodule
`default_nettype wire

// ----- design/psr_rot.sv -----
`default_nettype none
module psr_rot (
    input  wire logic       i_clk,
    input  psr_pkg::t_coord i_u,
    input  psr_pkg::t_coord i_v,
    input  psr_pkg::t_coord i_w,
    input  psr_pkg::t_coord i_c,
    input  psr_pkg::t_coord i_s,
    output psr_pkg::t_coord o_p,
    output psr_pkg::t_coord o_q,
    output psr_pkg::t_coord o_w
);

    localparam logic signed [psr_pkg::ACC_W-1:0] ROUND = 69'sd536870912;
    localparam logic signed [psr_pkg::ACC_W-1:0] LIM   = 69'sd4294967296;

    logic signed [psr_pkg::PROD_W-1:0] r_cu, r_sv, r_su, r_cv;
    psr_pkg::t_coord r_w1, r_p, r_q, r_w2;
    logic signed [psr_pkg::ACC_W-1:0] n_pa, n_qa;

    // p = c*u + s*v, q = c*v - s*u
    always_ff @(posedge i_clk) begin
        r_cu <= psr_pkg::PROD_W'(i_c) * psr_pkg::PROD_W'(i_u);
        r_sv <= psr_pkg::PROD_W'(i_s) * psr_pkg::PROD_W'(i_v);
        r_su <= psr_pkg::PROD_W'(i_s) * psr_pkg::PROD_W'(i_u);
        r_cv <= psr_pkg::PROD_W'(i_c) * psr_pkg::PROD_W'(i_v);
        r_w1 <= i_w;
    end

    function automatic psr_pkg::t_coord f_clamp(input logic signed [psr_pkg::ACC_W-1:0] a);
        psr_pkg::t_coord r;
        if (a > LIM) r = LIM[psr_pkg::CORD_W-1:0];
        else if (a < -LIM) r = psr_pkg::t_coord'(-LIM);
        else r = a[psr_pkg::CORD_W-1:0];
        return r;
    endfunction

    always_comb begin
        n_pa = (psr_pkg::ACC_W'(r_cu) + psr_pkg::ACC_W'(r_sv) + ROUND) >>> 30;
        n_qa = (psr_pkg::ACC_W'(r_cv) - psr_pkg::ACC_W'(r_su) + ROUND) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        r_p  <= f_clamp(n_pa);
        r_q  <= f_clamp(n_qa);
        r_w2 <= r_w1;
    end

    assign o_p = r_p;
    assign o_q = r_q;
    assign o_w = r_w2;

endmodule
`default_nettype wire

// ----- design/pole_spin_rotation.sv -----
`default_nettype none
// Rotates one Q16.16 vertex into the spinning body frame per transaction: about z by
// the pole longitude, about y from the pole latitude, then about z by the spin angle
// (low 32 bits of spin_rate * time). Fully pipelined: busy never rises, a transaction
// can start every cycle, and its result strobes on o_valid after the entry multiply,
// the fold plus one CORDIC iteration per stage, two stages per rotation and the output
// saturation. The receiver cannot stall; results must be taken.
module pole_spin_rotation #(
    parameter int unsigned CORDIC_ITERATIONS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [31:0] i_vertex_x,
    input  wire logic signed [31:0] i_vertex_y,
    input  wire logic signed [31:0] i_vertex_z,
    input  wire logic [31:0] i_time_value,
    output logic             o_valid,
    output logic signed [31:0] o_rotated_x,
    output logic signed [31:0] o_rotated_y,
    output logic signed [31:0] o_rotated_z,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned VDLY = CORDIC_ITERATIONS + 1;
    localparam int unsigned LAT  = CORDIC_ITERATIONS + 9;

    logic [15:0] r_lon;
    logic [15:0] r_lat;
    logic [31:0] r_rate;
    psr_pkg::t_reg_index n_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_idx  = psr_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lon  <= '0;
            r_lat  <= '0;
            r_rate <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (n_idx)
                psr_pkg::REG_POLE_LONGITUDE: r_lon  <= pwdata[15:0];
                psr_pkg::REG_POLE_LATITUDE:  r_lat  <= pwdata[15:0];
                psr_pkg::REG_SPIN_RATE:      r_rate <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            psr_pkg::REG_POLE_LONGITUDE: prdata = {16'd0, r_lon};
            psr_pkg::REG_POLE_LATITUDE:  prdata = {16'd0, r_lat};
            psr_pkg::REG_SPIN_RATE:      prdata = r_rate;
            default:                     prdata = '0;
        endcase
    end

    // valid travels alongside the data
    logic [LAT-1:0] r_vpipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vpipe <= '0;
        else r_vpipe <= {r_vpipe[LAT-2:0], start && !busy};
    end
    assign o_valid = r_vpipe[LAT-1];

    // entry stage
    logic [31:0] r_lon_ang, r_lat_ang, r_spin;
    psr_pkg::t_coord r_vx [0:VDLY];
    psr_pkg::t_coord r_vy [0:VDLY];
    psr_pkg::t_coord r_vz [0:VDLY];

    always_ff @(posedge i_clk) begin
        r_lon_ang <= {r_lon, 16'd0};
        r_lat_ang <= {r_lat, 16'd0};
        r_spin    <= 32'(r_rate * i_time_value);
        r_vx[0]   <= psr_pkg::t_coord'(i_vertex_x);
        r_vy[0]   <= psr_pkg::t_coord'(i_vertex_y);
        r_vz[0]   <= psr_pkg::t_coord'(i_vertex_z);
    end

    for (genvar k = 0; k < VDLY; k++) begin : g_vdly
        always_ff @(posedge i_clk) begin
            r_vx[k+1] <= r_vx[k];
            r_vy[k+1] <= r_vy[k];
            r_vz[k+1] <= r_vz[k];
        end
    end

    psr_pkg::t_coord w_cl, w_sl, w_cb, w_sb, w_cp, w_sp;

    psr_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_lon (
        .i_clk(i_clk), .i_ang(r_lon_ang), .o_cos(w_cl), .o_sin(w_sl)
    );
    psr_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_lat (
        .i_clk(i_clk), .i_ang(r_lat_ang), .o_cos(w_cb), .o_sin(w_sb)
    );
    psr_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_spin (
        .i_clk(i_clk), .i_ang(r_spin), .o_cos(w_cp), .o_sin(w_sp)
    );

    // align trig values with the rotation stages
    psr_pkg::t_coord r_cb [0:1];
    psr_pkg::t_coord r_sb [0:1];
    psr_pkg::t_coord r_cp [0:3];
    psr_pkg::t_coord r_sp [0:3];

    always_ff @(posedge i_clk) begin
        r_cb[0] <= w_cb;
        r_sb[0] <= w_sb;
        r_cb[1] <= r_cb[0];
        r_sb[1] <= r_sb[0];
        r_cp[0] <= w_cp;
        r_sp[0] <= w_sp;
        r_cp[1] <= r_cp[0];
        r_sp[1] <= r_sp[0];
        r_cp[2] <= r_cp[1];
        r_sp[2] <= r_sp[1];
        r_cp[3] <= r_cp[2];
        r_sp[3] <= r_sp[2];
    end

    psr_pkg::t_coord w_x1, w_y1, w_z1, w_x2, w_z2, w_y2, w_x3, w_y3, w_z3;
    psr_pkg::t_coord w_ncb;

    assign w_ncb = -r_cb[1];

    psr_rot u_rot_lon (
        .i_clk(i_clk), .i_u(r_vx[VDLY]), .i_v(r_vy[VDLY]), .i_w(r_vz[VDLY]),
        .i_c(w_cl), .i_s(w_sl), .o_p(w_x1), .o_q(w_y1), .o_w(w_z1)
    );
    psr_rot u_rot_lat (
        .i_clk(i_clk), .i_u(w_x1), .i_v(w_z1), .i_w(w_y1),
        .i_c(r_sb[1]), .i_s(w_ncb), .o_p(w_x2), .o_q(w_z2), .o_w(w_y2)
    );
    psr_rot u_rot_spin (
        .i_clk(i_clk), .i_u(w_x2), .i_v(w_y2), .i_w(w_z2),
        .i_c(r_cp[3]), .i_s(r_sp[3]), .o_p(w_x3), .o_q(w_y3), .o_w(w_z3)
    );

    function automatic logic signed [31:0] f_sat(input psr_pkg::t_coord a);
        logic signed [31:0] r;
        if (a > 34'sd2147483647) r = 32'sh7FFFFFFF;
        else if (a < -34'sd2147483648) r = 32'sh80000000;
        else r = a[31:0];
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        o_rotated_x <= f_sat(w_x3);
        o_rotated_y <= f_sat(w_y3);
        o_rotated_z <= f_sat(w_z3);
    end

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching transaction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_pipe_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vpipe[LAT-2] |=> o_valid)
        else $error("transaction lost in pipeline");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
module tb_top;

    localparam int unsigned N_ITER      = 24;
    localparam int unsigned N_PHASES    = 9;
    localparam int unsigned PER_PHASE   = 60;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam longint ROUND_HALF       = 64'sd536870912;
    localparam longint INTER_LIMIT      = 64'sh1_0000_0000;
    localparam longint GAIN_START       = 64'sd652032874;
    localparam longint ARC_TAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        t;
    } t_vertex;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_rotated;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_vertex_x = '0;
    logic signed [31:0] i_vertex_y = '0;
    logic signed [31:0] i_vertex_z = '0;
    logic [31:0]        i_time_value = '0;
    logic               o_valid;
    logic signed [31:0] o_rotated_x;
    logic signed [31:0] o_rotated_y;
    logic signed [31:0] o_rotated_z;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_vertex  vertex_queue [$];
    t_rotated rotation_expected [$];
    logic [15:0] cfg_longitude = '0;
    logic [15:0] cfg_latitude = '0;
    logic [31:0] cfg_spin_rate = '0;
    int n_mismatch = 0;
    int gap_left = 0;
    int stall_cycles = 0;
    bit no_gaps = 1'b0;

    pole_spin_rotation #(.CORDIC_ITERATIONS(N_ITER)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z),
        .i_time_value(i_time_value), .o_valid(o_valid),
        .o_rotated_x(o_rotated_x), .o_rotated_y(o_rotated_y), .o_rotated_z(o_rotated_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic void cordic_sin_cos(input logic [31:0] ang,
                                           output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit neg;
        z = longint'($signed(ang));
        x = GAIN_START;
        y = 0;
        neg = 1'b0;
        if (z > 64'sh4000_0000) begin
            z = z - 64'sh8000_0000;
            neg = 1'b1;
        end else if (z < -64'sh4000_0000) begin
            z = z + 64'sh8000_0000;
            neg = 1'b1;
        end
        for (int i = 0; i < N_ITER; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARC_TAN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARC_TAN[i];
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint row_sum(input longint a, input longint p,
                                       input longint b, input longint q);
        longint acc;
        acc = (a * p + b * q + ROUND_HALF) >>> 30;
        if (acc < -INTER_LIMIT) acc = -INTER_LIMIT;
        if (acc > INTER_LIMIT) acc = INTER_LIMIT;
        return acc;
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic t_rotated predict_rotation(input t_vertex v);
        longint cl, sl, cb, sb, cp, sp, x, y, z, nx, ny, nz;
        logic [31:0] spin;
        t_rotated r;
        spin = cfg_spin_rate * v.t;
        cordic_sin_cos({cfg_longitude, 16'h0}, cl, sl);
        cordic_sin_cos({cfg_latitude, 16'h0}, cb, sb);
        cordic_sin_cos(spin, cp, sp);
        x = longint'(v.x);
        y = longint'(v.y);
        z = longint'(v.z);
        nx = row_sum(cl, x, sl, y);
        ny = row_sum(-sl, x, cl, y);
        x = nx;
        y = ny;
        nx = row_sum(sb, x, -cb, z);
        nz = row_sum(cb, x, sb, z);
        x = nx;
        z = nz;
        nx = row_sum(cp, x, sp, y);
        ny = row_sum(-sp, x, cp, y);
        r.x = sat32(nx);
        r.y = sat32(ny);
        r.z = sat32(nz);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF - $urandom_range(3);
            1: return 32'sh8000_0000 + $urandom_range(3);
            2: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.x = rand_coord();
        v.y = rand_coord();
        v.z = rand_coord();
        v.t = ($urandom_range(3) == 0) ? 32'($urandom_range(255)) : $urandom;
        return v;
    endfunction

    task automatic reg_write(input psr_pkg::t_reg_index idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            psr_pkg::REG_POLE_LONGITUDE: cfg_longitude = val[15:0];
            psr_pkg::REG_POLE_LATITUDE:  cfg_latitude = val[15:0];
            psr_pkg::REG_SPIN_RATE:      cfg_spin_rate = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z, input logic [31:0] t);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.t = t;
        vertex_queue.push_back(v);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (vertex_queue.size() == 0) begin
                start <= 1'b0;
            end else if (!no_gaps && $urandom_range(5) == 0) begin
                gap_left <= $urandom_range(2);
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_vertex_x <= vertex_queue[0].x;
                i_vertex_y <= vertex_queue[0].y;
                i_vertex_z <= vertex_queue[0].z;
                i_time_value <= vertex_queue[0].t;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_vertex v;
        t_rotated e;
        bit progress;
        progress = 1'b0;
        if (start && !busy && i_rst_n) begin
            v.x = i_vertex_x;
            v.y = i_vertex_y;
            v.z = i_vertex_z;
            v.t = i_time_value;
            rotation_expected.push_back(predict_rotation(v));
            void'(vertex_queue.pop_front());
            progress = 1'b1;
        end
        if (psel && penable) progress = 1'b1;
        if (o_valid && i_rst_n) begin
            progress = 1'b1;
            if (rotation_expected.size() == 0) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("unexpected transaction: x=%0d y=%0d z=%0d",
                             o_rotated_x, o_rotated_y, o_rotated_z);
            end else begin
                e = rotation_expected.pop_front();
                if (e.x !== o_rotated_x || e.y !== o_rotated_y || e.z !== o_rotated_z) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 e.x, e.y, e.z, o_rotated_x, o_rotated_y, o_rotated_z);
                end
            end
        end
        stall_cycles <= progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [15:0] lon [N_PHASES];
        logic [15:0] lat [N_PHASES];
        logic [31:0] rate [N_PHASES];
        lon  = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'h2000, 16'h0, 16'h0, 16'h0, 16'h0};
        lat  = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0};
        rate = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h0001_0000,
                 32'h0, 32'h0, 32'h0, 32'h0};
        for (int p = 5; p < N_PHASES; p++) begin
            lon[p] = 16'($urandom);
            lat[p] = (p == 6) ? 16'($urandom) : 16'($urandom_range(32768) - 16384);
            rate[p] = $urandom;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < N_PHASES; p++) begin
            reg_write(psr_pkg::REG_POLE_LONGITUDE, {16'($urandom), lon[p]});
            reg_write(psr_pkg::REG_POLE_LATITUDE, {16'($urandom), lat[p]});
            reg_write(psr_pkg::REG_SPIN_RATE, rate[p]);
            reg_write(psr_pkg::REG_UNUSED, $urandom);
            if (p == 0) begin
                push_vertex(0, 0, 0, 0);
                push_vertex(32'sh0001_0000, 0, 0, 0);
                push_vertex(0, 32'sh0001_0000, 0, 32'hFFFF_FFFF);
                push_vertex(0, 0, 32'sh0001_0000, 32'h1);
                push_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
                push_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
                push_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
                push_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h8000_0000);
                push_vertex(-1, -1, -1, 32'h5555_5555);
                push_vertex(1, 1, 1, 32'hAAAA_AAAA);
                for (int k = 0; k < 10; k++) vertex_queue.push_back(rand_vertex());
            end
            if (p == 1) begin
                push_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h3FFF_FFFF);
                push_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h2000_0000);
            end
            if (p == N_PHASES - 1) no_gaps = 1'b1;
            for (int k = 0; k < PER_PHASE; k++) vertex_queue.push_back(rand_vertex());
            while (vertex_queue.size() != 0 || rotation_expected.size() != 0)
                @(posedge i_clk);
            repeat (DRAIN_WAIT) @(posedge i_clk);
        end
        if (n_mismatch == 0 && rotation_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
